// File: rtl/core/gwwb_pkg.sv
// ============================================================================
// gwwb_pkg: shared types and constants of the word wrap line breaker
// Field widths, character codes, break causes and the transaction structs
// that travel between the stages of the breaker.
// ============================================================================
package gwwb_pkg;

    localparam int CODE_W  = 16;
    localparam int ADV_W   = 10;
    localparam int WIDTH_W = 22;
    localparam int OFF_W   = 13;

    localparam logic [OFF_W-1:0]   MAX_LINE_CHARS = OFF_W'(4096);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX      = {WIDTH_W{1'b1}};

    localparam logic [CODE_W-1:0] CH_LF       = 16'h000A;
    localparam logic [CODE_W-1:0] CH_CR       = 16'h000D;
    localparam logic [CODE_W-1:0] CH_TAB      = 16'h0009;
    localparam logic [CODE_W-1:0] CH_SPACE    = 16'h0020;
    localparam logic [CODE_W-1:0] CH_BACKTICK = 16'h0060;
    localparam logic [CODE_W-1:0] CH_RETURN_ARROW = 16'h21B2;

    typedef enum logic [2:0] {
        END_RANGE      = 3'd0,
        END_NEWLINE    = 3'd1,
        END_WRAP_SPACE = 3'd2,
        END_WRAP_CHAR  = 3'd3,
        END_FORCED     = 3'd4
    } end_cause_t;

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic [ADV_W-1:0]  advance;
        logic              begin_req;
        logic              range_end;
    } char_item_t;

    typedef struct packed {
        logic [OFF_W-1:0]   break_offset;
        logic [WIDTH_W-1:0] line_width;
        end_cause_t         ended_by;
    } break_item_t;

    function automatic logic is_white(input logic [CODE_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_RETURN_ARROW) ||
               (c == CH_BACKTICK);
    endfunction

endpackage

// File: rtl/core/gwwb_ifs.sv
// ============================================================================
// gwwb_ifs: channel interfaces of the word wrap line breaker
// A character channel and a break channel, each with valid, ready and payload.
// ============================================================================
interface gwwb_char_if;
    logic                          valid;
    logic                          ready;
    logic [gwwb_pkg::CODE_W-1:0]   char_code;
    logic [gwwb_pkg::ADV_W-1:0]    advance;
    logic                          begin_req;
    logic                          range_end;

    modport source (output valid, char_code, advance, begin_req, range_end, input ready);
    modport sink   (input valid, char_code, advance, begin_req, range_end, output ready);
endinterface

interface gwwb_break_if;
    logic                          valid;
    logic                          ready;
    logic [gwwb_pkg::OFF_W-1:0]    break_offset;
    logic [gwwb_pkg::WIDTH_W-1:0]  line_width;
    logic [2:0]                    ended_by;

    modport source (output valid, break_offset, line_width, ended_by, input ready);
    modport sink   (input valid, break_offset, line_width, ended_by, output ready);
endinterface

// File: rtl/core/gwwb_in_stage.sv
// ============================================================================
// gwwb_in_stage: input register of the breaker
// Captures one character transaction and holds it until the core takes it.
// ============================================================================
module gwwb_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gwwb_pkg::char_item_t in_item,
    input  logic                 take,
    output logic                 item_valid,
    output gwwb_pkg::char_item_t item
);
    import gwwb_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    char_item_t item_reg;

    // The register frees up in the same cycle that the core consumes it.
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/core/gwwb_core.sv
// ============================================================================
// gwwb_core: line state and break decision
// Holds the running line state and decides, per character, whether a line
// ends and why.
// ============================================================================
module gwwb_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [gwwb_pkg::WIDTH_W-1:0]  cfg_wr_data,
    input  logic                          fire,
    input  gwwb_pkg::char_item_t          item,
    output logic                          res_valid,
    output gwwb_pkg::break_item_t         res
);
    import gwwb_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_MEASURE = 2'd1,
        PH_SKIP    = 2'd2
    } phase_t;

    logic [WIDTH_W-1:0] max_width_reg;
    logic [WIDTH_W-1:0] pen_reg, pen_next;
    logic [OFF_W-1:0]   cnt_reg, cnt_next;
    logic               space_reg, space_next;
    logic [OFF_W-1:0]   oas_reg, oas_next;
    logic [WIDTH_W-1:0] wts_reg, wts_next;
    logic               run_reg, run_next;
    logic               cr_reg, cr_next;
    phase_t             phase_reg, phase_next;

    // State as seen after a possible begin of request.
    logic [WIDTH_W-1:0] pen0, wts0;
    logic [OFF_W-1:0]   cnt0, oas0;
    logic               space0, run0, cr0;
    phase_t             phase0;

    logic [WIDTH_W:0]   pen_sum;
    logic [WIDTH_W-1:0] newpen;
    logic [OFF_W-1:0]   cnt_inc;
    logic [OFF_W-1:0]   oas_inc;
    logic               white;
    logic               is_space;

    always_comb
    begin
        if (item.begin_req)
        begin
            pen0   = '0;
            cnt0   = '0;
            space0 = 1'b0;
            oas0   = '0;
            wts0   = '0;
            run0   = 1'b0;
            cr0    = 1'b0;
            phase0 = PH_MEASURE;
        end
        else
        begin
            pen0   = pen_reg;
            cnt0   = cnt_reg;
            space0 = space_reg;
            oas0   = oas_reg;
            wts0   = wts_reg;
            run0   = run_reg;
            cr0    = cr_reg;
            phase0 = phase_reg;
        end
    end

    assign pen_sum  = {1'b0, pen0} + (WIDTH_W+1)'(item.advance);
    assign newpen   = pen_sum[WIDTH_W] ? WIDTH_MAX : pen_sum[WIDTH_W-1:0];
    assign cnt_inc  = cnt0 + 1'b1;
    assign oas_inc  = oas0 + 1'b1;
    assign white    = is_white(item.char_code);
    assign is_space = (item.char_code == CH_SPACE) || (item.char_code == CH_TAB);

    always_comb
    begin
        pen_next   = pen0;
        cnt_next   = cnt0;
        space_next = space0;
        oas_next   = oas0;
        wts_next   = wts0;
        run_next   = run0;
        cr_next    = cr0;
        phase_next = phase0;
        res_valid  = 1'b0;
        res.break_offset = oas0;
        res.line_width   = wts0;
        res.ended_by     = END_WRAP_SPACE;

        case (phase0)
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            PH_SKIP:
            begin
                if (!white)
                begin
                    res_valid  = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    oas_next = oas_inc;
                    if (item.range_end || (oas_inc >= MAX_LINE_CHARS))
                    begin
                        res_valid        = 1'b1;
                        res.break_offset = oas_inc;
                        phase_next       = PH_IDLE;
                    end
                end
            end
            PH_MEASURE:
            begin
                if (item.char_code == CH_LF)
                begin
                    res_valid        = 1'b1;
                    res.break_offset = cnt_inc;
                    res.line_width   = newpen;
                    res.ended_by     = END_NEWLINE;
                    phase_next       = PH_IDLE;
                end
                else if (cr0)
                begin
                    // A lone CR ends the line before this character.
                    res_valid        = 1'b1;
                    res.break_offset = cnt0;
                    res.line_width   = pen0;
                    res.ended_by     = END_NEWLINE;
                    phase_next       = PH_IDLE;
                end
                else
                begin
                    if (is_space)
                    begin
                        space_next = 1'b1;
                        oas_next   = cnt_inc;
                        wts_next   = newpen;
                        run_next   = 1'b1;
                    end
                    else if (run0 && white)
                    begin
                        oas_next = oas_inc;
                    end
                    else
                    begin
                        run_next = 1'b0;
                    end

                    if (newpen > max_width_reg)
                    begin
                        if (space_next)
                        begin
                            if (run_next && !item.range_end &&
                                (oas_next < MAX_LINE_CHARS))
                            begin
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                res_valid        = 1'b1;
                                res.break_offset = oas_next;
                                res.line_width   = wts_next;
                                res.ended_by     = END_WRAP_SPACE;
                                phase_next       = PH_IDLE;
                            end
                        end
                        else if (cnt0 != '0)
                        begin
                            res_valid        = 1'b1;
                            res.break_offset = cnt0;
                            res.line_width   = pen0;
                            res.ended_by     = END_WRAP_CHAR;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            res_valid        = 1'b1;
                            res.break_offset = OFF_W'(1);
                            res.line_width   = WIDTH_W'(item.advance);
                            res.ended_by     = END_FORCED;
                            phase_next       = PH_IDLE;
                        end
                    end
                    else
                    begin
                        pen_next = newpen;
                        cnt_next = cnt_inc;
                        cr_next  = (item.char_code == CH_CR);
                        if (item.range_end || (cnt_inc >= MAX_LINE_CHARS))
                        begin
                            res_valid        = 1'b1;
                            res.break_offset = cnt_inc;
                            res.line_width   = newpen;
                            res.ended_by     = END_RANGE;
                            phase_next       = PH_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_width_reg <= WIDTH_MAX;
            pen_reg       <= '0;
            cnt_reg       <= '0;
            space_reg     <= 1'b0;
            oas_reg       <= '0;
            wts_reg       <= '0;
            run_reg       <= 1'b0;
            cr_reg        <= 1'b0;
            phase_reg     <= PH_IDLE;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_width_reg <= cfg_wr_data;
            end
            if (fire)
            begin
                pen_reg   <= pen_next;
                cnt_reg   <= cnt_next;
                space_reg <= space_next;
                oas_reg   <= oas_next;
                wts_reg   <= wts_next;
                run_reg   <= run_next;
                cr_reg    <= cr_next;
                phase_reg <= phase_next;
            end
        end
    end

endmodule

// File: rtl/core/gwwb_out_stage.sv
// ============================================================================
// gwwb_out_stage: result register of the breaker
// Holds one break result until the downstream side takes it.
// ============================================================================
module gwwb_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  res_valid,
    input  gwwb_pkg::break_item_t res,
    output logic                  free,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gwwb_pkg::break_item_t out_item
);
    import gwwb_pkg::*;

    logic        valid_reg;
    break_item_t data_reg;

    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= res_valid;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = data_reg;

endmodule

// File: rtl/core/greedy_word_wrap_breaker.sv
// ============================================================================
// greedy_word_wrap_breaker: greedy word wrap line breaker
// Sums character advances of one break request and reports where the line
// breaks, how wide it is and what ended it.
// ============================================================================
//
//  Channel   Direction  Payload                                   Per transaction
//  chars     in         char_code, advance, begin_req, range_end  one character
//  breaks    out        break_offset, line_width, ended_by        one line break
//  cfg       in         cfg_wr_data (max_line_width)              register write
//
// One character is accepted in every cycle unless the break channel stalls.
// It waits in the character register, and its break result is registered in
// the result register, from which it shows up on the output.
// The rate is set by the single line state update, an add with saturation
// and a compare against the width limit, done once per character.
// Reset clears the line state, returns the breaker to idle and sets the width
// limit to its largest value; no clearing pass is needed.
// A stall on the break channel holds the result register, and the character
// register behind it fills and then holds the character channel back.

module greedy_word_wrap_breaker (
    input  logic                          clk,
    input  logic                          rst_n,
    gwwb_char_if.sink                     chars,
    gwwb_break_if.source                  breaks,
    input  logic                          cfg_wr_en,
    input  logic [gwwb_pkg::WIDTH_W-1:0]  cfg_wr_data
);
    import gwwb_pkg::*;

    char_item_t  in_item;
    char_item_t  item;
    logic        item_valid;
    logic        take;
    logic        out_free;
    logic        res_valid;
    break_item_t res;
    break_item_t out_item;

    assign in_item.char_code = chars.char_code;
    assign in_item.advance   = chars.advance;
    assign in_item.begin_req = chars.begin_req;
    assign in_item.range_end = chars.range_end;

    // The core works on the held character whenever the result register can
    // take whatever that character produces, including no result at all.
    assign take = item_valid && out_free;

    gwwb_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (chars.valid),
        .in_ready   (chars.ready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    gwwb_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (take),
        .item        (item),
        .res_valid   (res_valid),
        .res         (res)
    );

    gwwb_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .out_valid (breaks.valid),
        .out_ready (breaks.ready),
        .out_item  (out_item)
    );

    // The break channel carries the cause as a plain three-bit code.
    assign breaks.break_offset = out_item.break_offset;
    assign breaks.line_width   = out_item.line_width;
    assign breaks.ended_by     = 3'(out_item.ended_by);

endmodule

// File: rtl/core/gwwb_checker.sv
// ============================================================================
// gwwb_checker: port-level checks of the word wrap line breaker
// Watches the break channel and is bound to the top level.
// ============================================================================
module gwwb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [gwwb_pkg::OFF_W-1:0]    break_offset,
    input logic [gwwb_pkg::WIDTH_W-1:0]  line_width,
    input logic [2:0]                    ended_by
);
    import gwwb_pkg::*;

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("break result dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(break_offset) && $stable(line_width) &&
                                    $stable(ended_by))
        else $error("break result changed while stalled");

    a_offset_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> break_offset != '0)
        else $error("a line ended with no characters");

    a_forced_one_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ended_by == 3'(END_FORCED) |->
            break_offset == OFF_W'(1) && line_width <= WIDTH_W'({ADV_W{1'b1}}))
        else $error("forced break does not keep exactly one character");

endmodule

bind greedy_word_wrap_breaker gwwb_checker u_gwwb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (breaks.valid),
    .out_ready    (breaks.ready),
    .break_offset (breaks.break_offset),
    .line_width   (breaks.line_width),
    .ended_by     (breaks.ended_by)
);

// File: tb/gwwb_tb_pkg.sv
// ============================================================================
// gwwb_tb_pkg: line break scoreboard for the word wrap breaker testbench
// Keeps its own copy of the line state and width limit, works out the line
// break that each accepted character causes and checks the breaks that come
// out of the block in order.
// ============================================================================
package gwwb_tb_pkg;

    import gwwb_pkg::*;

    typedef enum logic [1:0] {
        LINE_IDLE,
        LINE_MEASURE,
        LINE_SKIP
    } line_phase_t;

    class line_break_scoreboard;

        logic [WIDTH_W-1:0] width_limit;
        int unsigned        pen;
        int unsigned        kept;
        int unsigned        ws_offset;
        int unsigned        ws_width;
        bit                 space_noted;
        bit                 ws_run;
        bit                 after_cr;
        line_phase_t        phase;

        break_item_t        expected_breaks[$];
        int unsigned        failures;
        int unsigned        checked;
        int unsigned        busy_chars;
        int unsigned        cause_count[5];

        function new();
            width_limit = WIDTH_MAX;
            phase       = LINE_IDLE;
            failures    = 0;
            checked     = 0;
            busy_chars  = 0;
            foreach (cause_count[i])
                cause_count[i] = 0;
            clear_line();
        endfunction

        function void clear_line();
            pen         = 0;
            kept        = 0;
            ws_offset   = 0;
            ws_width    = 0;
            space_noted = 1'b0;
            ws_run      = 1'b0;
            after_cr    = 1'b0;
        endfunction

        function bit is_blank(logic [CODE_W-1:0] code);
            case (code)
                CH_SPACE, CH_TAB, CH_RETURN_ARROW, CH_BACKTICK: return 1'b1;
                default:                                        return 1'b0;
            endcase
        endfunction

        function void post_break(int unsigned offset, int unsigned width, end_cause_t cause);
            break_item_t b;
            b.break_offset  = OFF_W'(offset);
            b.line_width    = WIDTH_W'(width);
            b.ended_by      = cause;
            expected_breaks = {expected_breaks, b};
            phase           = LINE_IDLE;
        endfunction

        // Advances the line state by one accepted character.
        function void note_char(char_item_t c);
            int unsigned adv;
            int unsigned newpen;
            int unsigned line_cap;
            adv      = c.advance;
            line_cap = MAX_LINE_CHARS;
            if (c.begin_req)
            begin
                clear_line();
                phase = LINE_MEASURE;
            end
            if (phase == LINE_IDLE)
                return;
            busy_chars++;

            if (phase == LINE_SKIP)
            begin
                if (!is_blank(c.char_code))
                begin
                    post_break(ws_offset, ws_width, END_WRAP_SPACE);
                    return;
                end
                ws_offset++;
                if (c.range_end || ws_offset >= line_cap)
                    post_break(ws_offset, ws_width, END_WRAP_SPACE);
                return;
            end

            newpen = pen + adv;
            if (newpen > WIDTH_MAX)
                newpen = WIDTH_MAX;

            if (c.char_code == CH_LF)
            begin
                post_break(kept + 1, newpen, END_NEWLINE);
                return;
            end
            if (after_cr)
            begin
                post_break(kept, pen, END_NEWLINE);
                return;
            end

            if (c.char_code == CH_SPACE || c.char_code == CH_TAB)
            begin
                space_noted = 1'b1;
                ws_offset   = kept + 1;
                ws_width    = newpen;
                ws_run      = 1'b1;
            end
            else if (ws_run && is_blank(c.char_code))
            begin
                ws_offset++;
            end
            else
            begin
                ws_run = 1'b0;
            end

            if (newpen > width_limit)
            begin
                if (space_noted)
                begin
                    if (ws_run && !c.range_end && ws_offset < line_cap)
                    begin
                        phase = LINE_SKIP;
                        return;
                    end
                    post_break(ws_offset, ws_width, END_WRAP_SPACE);
                    return;
                end
                if (kept > 0)
                    post_break(kept, pen, END_WRAP_CHAR);
                else
                    post_break(1, adv, END_FORCED);
                return;
            end

            pen      = newpen;
            kept++;
            after_cr = (c.char_code == CH_CR);
            if (c.range_end || kept >= line_cap)
                post_break(kept, pen, END_RANGE);
        endfunction

        // Compares one break from the block with the oldest one predicted.
        function void check_break(break_item_t got);
            break_item_t want;
            if (expected_breaks.size() == 0)
            begin
                $error("unexpected line break: break_offset %0d line_width %0d ended_by %0d",
                       got.break_offset, got.line_width, got.ended_by);
                failures++;
                return;
            end
            want = expected_breaks.pop_front();
            checked++;
            cause_count[int'(want.ended_by)]++;
            if (got.break_offset !== want.break_offset)
            begin
                $error("break_offset: expected %0d, actual %0d",
                       want.break_offset, got.break_offset);
                failures++;
            end
            if (got.line_width !== want.line_width)
            begin
                $error("line_width: expected %0d, actual %0d",
                       want.line_width, got.line_width);
                failures++;
            end
            if (got.ended_by !== want.ended_by)
            begin
                $error("ended_by: expected %0d, actual %0d",
                       want.ended_by, got.ended_by);
                failures++;
            end
        endfunction

    endclass

endpackage

// File: tb/testbench.sv
// ============================================================================
// testbench: regression of the greedy word wrap line breaker
// Drives break requests as character transactions, with directed corner
// cases first and then random text under several width limits, and checks
// every line break against an independent line state predictor.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import gwwb_pkg::*;
    import gwwb_tb_pkg::*;

    // Characters sent in the random phases, spread evenly over them.
    localparam int RANDOM_CHARS    = 1700;
    localparam int RANDOM_PHASES   = 6;
    // The receiver holds off this long once, so the block fills and stalls.
    localparam int HOLD_OFF_CYCLES = 400;
    // Cycles without any transaction before the run is declared hung. The
    // longest correct silence is the hold-off plus a few sender gaps.
    localparam int WATCHDOG_LIMIT  = 3000;
    // Pause after the last break, covering the character and result registers.
    localparam int SETTLE_CYCLES   = 4;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [WIDTH_W-1:0] cfg_wr_data;

    gwwb_char_if  chars_if ();
    gwwb_break_if breaks_if ();

    line_break_scoreboard sb;

    // When steady is set neither side idles; hold_off_req asks the receiver
    // for one long stall.
    bit          steady;
    bit          hold_off_req;
    int unsigned limits_used;
    int unsigned sent_chars;

    greedy_word_wrap_breaker u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars_if),
        .breaks      (breaks_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitor. Both channels are sampled at the rising edge, so the values
    // seen are the ones that the block saw at that edge. The character is
    // noted first; its break cannot show up in the same cycle anyway.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        char_item_t  ci;
        break_item_t bi;
        if (chars_if.valid && chars_if.ready)
        begin
            ci.char_code = chars_if.char_code;
            ci.advance   = chars_if.advance;
            ci.begin_req = chars_if.begin_req;
            ci.range_end = chars_if.range_end;
            sb.note_char(ci);
        end
        if (breaks_if.valid && breaks_if.ready)
        begin
            bi.break_offset = breaks_if.break_offset;
            bi.line_width   = breaks_if.line_width;
            bi.ended_by     = end_cause_t'(breaks_if.ended_by);
            sb.check_break(bi);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. It stalls at random, with a chance of about six percent, except while the
    // run is steady. On request it holds ready low for a long stretch while
    // the sender keeps offering characters.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        breaks_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                breaks_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            breaks_if.ready <= steady || ($urandom_range(99) >= 6);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. Any transaction on either channel restarts the count; a
    // hung block or a lost break ends the run as a failure.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (chars_if.valid && chars_if.ready) ||
                (breaks_if.valid && breaks_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("greedy_word_wrap_breaker regression: fail");
        $finish;
    end

    // Offers one character and returns at the edge where it is accepted.
    // Before the offer the sender may go idle for one cycle.
    task automatic send_char(input logic [CODE_W-1:0] code, input int unsigned adv,
                             input bit first, input bit last);
        if (!steady && $urandom_range(99) < 6)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid     <= 1'b1;
        chars_if.char_code <= code;
        chars_if.advance   <= ADV_W'(adv);
        chars_if.begin_req <= first;
        chars_if.range_end <= last;
        @(posedge clk);
        while (!chars_if.ready) @(posedge clk);
        sent_chars++;
    endtask

    // Sends a string as one request, every character with the same advance.
    task automatic send_text(input string s, input int unsigned adv, input bit last_ends);
        for (int i = 0; i < s.len(); i++)
            send_char({8'h00, s[i]}, adv, i == 0, last_ends && (i == s.len() - 1));
    endtask

    // Lets the block run dry: every predicted break out, then a short pause
    // for characters that were accepted but cause no break.
    task automatic settle();
        chars_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_breaks.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the width limit; only called once the block has settled.
    task automatic set_width_limit(input int unsigned limit);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= WIDTH_W'(limit);
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        sb.width_limit = WIDTH_W'(limit);
        limits_used++;
    endtask

    // Mostly letters, with a good share of every whitespace kind, line
    // endings and arbitrary 16-bit code units.
    function automatic logic [CODE_W-1:0] pick_code();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)      return CODE_W'(16'h0061 + $urandom_range(25));
        else if (r < 67) return CH_SPACE;
        else if (r < 71) return CH_TAB;
        else if (r < 74) return CH_BACKTICK;
        else if (r < 77) return CH_RETURN_ARROW;
        else if (r < 80) return CH_LF;
        else if (r < 83) return CH_CR;
        else             return CODE_W'($urandom_range(16'hFFFF));
    endfunction

    // Small advances dominate so that lines hold several words; zero, the
    // largest advance and the full range show up too.
    function automatic int unsigned pick_advance();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)       return 0;
        else if (r < 12) return 1023;
        else if (r < 30) return $urandom_range(1023);
        else             return $urandom_range(1, 40);
    endfunction

    // One random request. A tidy request opens with begin_req and closes
    // with range_end, so it always yields a break. The rest is noise: it may
    // lack the closing mark and be cut off by the next request, or lack the
    // opening mark and be ignored or extend whatever line is open.
    task automatic send_request(input int unsigned max_len);
        int unsigned len;
        bit          tidy;
        bit          opened;
        len    = $urandom_range(1, max_len);
        tidy   = $urandom_range(99) >= 12;
        opened = tidy || ($urandom_range(1) == 1);
        for (int i = 0; i < len; i++)
            send_char(pick_code(), pick_advance(), opened && (i == 0),
                      tidy && (i == len - 1));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned limits[RANDOM_PHASES];
        int unsigned goal;

        sb           = new();
        steady       = 1'b0;
        hold_off_req = 1'b0;
        limits_used  = 0;
        sent_chars   = 0;

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        chars_if.valid     = 1'b0;
        chars_if.char_code = '0;
        chars_if.advance   = '0;
        chars_if.begin_req = 1'b0;
        chars_if.range_end = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- Widest limit: range ends, newlines, idle input, restarts -------
        set_width_limit(WIDTH_MAX);
        // A character with no request open is ignored.
        send_char(16'h007A, 7, 1'b0, 1'b0);
        // Largest code unit and advance as a one-character request.
        send_char(16'hFFFF, 1023, 1'b1, 1'b1);
        // LF stays on the line it ends.
        send_text("ab\n", 1023, 1'b0);
        // A lone CR ends the line at the character after it.
        send_text("x\ry", 9, 1'b0);
        // A new begin drops the open line without a break.
        send_text("pq", 3, 1'b0);
        send_char(16'h0000, 0, 1'b1, 1'b1);
        settle();

        // --- Narrow limit: every kind of wrap ---------------------------------
        set_width_limit(20);
        // Wrap after the space once a later word overflows.
        send_text("ab cd", 5, 1'b0);
        // No space: break before the overflowing character.
        send_text("abcde", 5, 1'b0);
        // Empty line and one wide character: it is kept alone.
        send_char(16'h0057, 30, 1'b1, 1'b0);
        // Overflow inside a whitespace run: the run after the wrap point is
        // skipped, backtick and return arrow included, up to the next word.
        send_text("ab ", 5, 1'b0);
        send_char(CH_TAB, 10, 1'b0, 1'b0);
        send_char(CH_BACKTICK, 1, 1'b0, 1'b0);
        send_char(CH_RETURN_ARROW, 1, 1'b0, 1'b0);
        send_char(16'h0078, 1, 1'b0, 1'b0);
        // Skipping also ends on a range end.
        send_char(16'h0061, 5, 1'b1, 1'b0);
        send_char(CH_SPACE, 20, 1'b0, 1'b0);
        send_char(CH_SPACE, 1, 1'b0, 1'b1);
        // Backtick and return arrow only extend the run after a space.
        send_text("a ", 5, 1'b0);
        send_char(CH_RETURN_ARROW, 5, 1'b0, 1'b0);
        send_char(CH_BACKTICK, 5, 1'b0, 1'b0);
        send_char(16'h0062, 5, 1'b0, 1'b0);
        // Overflow on a space that is also the range end: no skipping.
        send_char(16'h0061, 5, 1'b1, 1'b0);
        send_char(CH_SPACE, 20, 1'b0, 1'b1);
        settle();

        // A second space moves the wrap point; the skipped run then ends on
        // the next word.
        set_width_limit(10);
        send_text("a  ", 5, 1'b0);
        send_char(CH_SPACE, 0, 1'b0, 1'b0);
        send_char(CH_SPACE, 0, 1'b0, 1'b0);
        send_char(16'h0062, 0, 1'b0, 1'b0);
        settle();

        // --- Zero limit: only zero advances fit -------------------------------
        set_width_limit(0);
        send_char(16'h0061, 0, 1'b1, 1'b0);
        send_char(16'h0062, 0, 1'b0, 1'b1);
        send_char(16'h0061, 1, 1'b1, 1'b0);
        settle();

        // --- Random text under several limits ---------------------------------
        // The second phase carries the long receiver stall; the fourth runs
        // with no idling on either side.
        limits[0] = 150;
        limits[1] = $urandom_range(64, 2000);
        limits[2] = 0;
        limits[3] = $urandom_range(1, 63);
        limits[4] = WIDTH_MAX;
        limits[5] = $urandom_range(WIDTH_MAX);
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_width_limit(limits[p]);
            steady = (p == 3);
            if (p == 1)
            begin
                // Short requests, each one a break, keep the block filling
                // up while the receiver holds off.
                hold_off_req = 1'b1;
                repeat (40) send_char(pick_code(), pick_advance(), 1'b1, 1'b1);
            end
            goal = sent_chars + RANDOM_CHARS / RANDOM_PHASES;
            while (sent_chars < goal)
                send_request(40);
            settle();
        end
        steady = 1'b0;

        $display("Checked %0d line breaks over %0d characters sent, %0d of them working,",
                 sb.checked, sent_chars, sb.busy_chars);
        $display("under %0d width limits. Causes seen: %0d range end, %0d newline,",
                 limits_used, sb.cause_count[END_RANGE], sb.cause_count[END_NEWLINE]);
        $display("%0d space wrap, %0d char wrap, %0d forced",
                 sb.cause_count[END_WRAP_SPACE], sb.cause_count[END_WRAP_CHAR],
                 sb.cause_count[END_FORCED]);
        if (sb.failures == 0)
            $display("greedy_word_wrap_breaker regression: pass");
        else
            $display("greedy_word_wrap_breaker regression: fail");
        $finish;
    end

endmodule
